/* rtl/i2c_master_transaction_sequencer_macros.svh */
// assertion macros for the i2c master transaction sequencer
// expects clk and arst_n in the scope of use
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH

// same-cycle implication
`define I2CMTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define I2CMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/i2cmts_pkg.sv */
// shared types, codes and constants of the i2c master transaction sequencer
// no dependencies
package i2cmts_pkg;

	localparam int WRITE_DEPTH_DEF = 16;
	localparam int READ_DEPTH = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 7;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_START = 2'd1,
		ACT_BUS   = 2'd2,
		ACT_ERROR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BUSY   = 2'd1,
		ST_NACK   = 2'd2,
		ST_BUSERR = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CTL_KEEP    = 2'd0,
		CTL_ENABLE  = 2'd1,
		CTL_DISABLE = 2'd2
	} ctl_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TARGET   = 2'd0,
		CFG_WR_LEN   = 2'd1,
		CFG_RD_LEN   = 2'd2,
		CFG_REP_START = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_ADDR  = 3'd2,
		PH_TX    = 3'd3,
		PH_RX    = 3'd4,
		PH_DONE  = 3'd5,
		PH_ERROR = 3'd6
	} phase_t;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] load_index;
		logic [7:0] load_byte;
		logic       bus_busy;
		logic       flag_start_sent;
		logic       flag_address_acked;
		logic       flag_byte_done;
		logic       flag_tx_empty;
		logic       flag_rx_ready;
		logic [7:0] rx_byte;
		logic       flag_nack;
		logic       flag_bus_error;
	} in_t;

	typedef struct packed {
		logic [1:0] status;
		logic       data_write_valid;
		logic [7:0] data_write_value;
		logic       issue_start;
		logic       issue_stop;
		logic [1:0] ack_control;
		logic [1:0] buffer_irq_control;
		logic [1:0] event_irq_control;
		logic       read_valid;
		logic [3:0] read_index;
		logic [7:0] read_value;
		logic       finished;
	} out_t;

	typedef struct packed {
		logic [6:0] target_address;
		logic [4:0] write_length;
		logic [4:0] read_length;
		logic       restart_en;
	} cfg_t;

	typedef struct packed {
		phase_t     phase;
		logic       active;
		logic [1:0] last_status;
		logic [4:0] sent_count;
		logic [4:0] received_count;
		logic [4:0] remaining_write_length;
	} state_t;

endpackage

/* rtl/i2c_master_transaction_sequencer.sv */
// top level of the i2c master transaction sequencer: config registers,
// input stage, state, write buffer and result register
// depends on i2cmts_pkg, i2cmts_ram, i2cmts_step and the macros header
//
// channel   direction  handshake                  payload
// config    in         cfg_write                  cfg_index, cfg_data
// item      in         item_valid / item_stall    item (in_t)
// result    out        result_valid / result_stall result (out_t)
//
// one item per cycle while item_stall is low; an accepted item passes the input stage,
// then the result register, the input stage giving the registered buffer read time
// reset clears config, state and both valid flags; the buffer holds no reset
// item_stall rises only while both the input stage and result register are full
// and the result side stalls
`include "i2c_master_transaction_sequencer_macros.svh"

module i2c_master_transaction_sequencer #(
	parameter int WRITE_DEPTH = i2cmts_pkg::WRITE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [i2cmts_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [i2cmts_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  i2cmts_pkg::in_t                    item,
	output logic                               result_valid,
	input  logic                               result_stall,
	output i2cmts_pkg::out_t                   result
);
	import i2cmts_pkg::*;

	localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

	cfg_t       cfg_q;
	state_t     st_q;
	state_t     st_next;
	in_t        item_s1;
	logic       valid_s1;
	out_t       res_d;
	out_t       res_q;
	logic       res_valid_q;
	logic       accept;
	logic       s1_go;
	logic [4:0] sc_next;
	logic [8:0] rd_wide;
	logic [8:0] wr_wide;
	logic       buf_we;
	logic [7:0] buf_byte;

	assign item_stall = valid_s1 && res_valid_q && result_stall;
	assign accept = item_valid && !item_stall;
	assign s1_go = valid_s1 && (!res_valid_q || !result_stall);
	assign result_valid = res_valid_q;
	assign result = res_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TARGET: cfg_q.target_address <= cfg_data;
				CFG_WR_LEN: cfg_q.write_length <= cfg_data[4:0];
				CFG_RD_LEN: cfg_q.read_length <= cfg_data[4:0];
				CFG_REP_START: cfg_q.restart_en <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// write buffer: loads go in at acceptance, reads prefetch the next send slot
	assign wr_wide = 9'(item.load_index);
	assign buf_we = accept && (item.action == ACT_LOAD) && (wr_wide < 9'(WRITE_DEPTH));
	assign sc_next = s1_go ? st_next.sent_count : st_q.sent_count;
	assign rd_wide = (9'(sc_next) < 9'(WRITE_DEPTH)) ? 9'(sc_next) : '0;

	i2cmts_ram #(
		.WIDTH(8),
		.DEPTH(WRITE_DEPTH),
		.AW(AW)
	) u_buf (
		.clk(clk),
		.we(buf_we),
		.waddr(wr_wide[AW-1:0]),
		.wdata(item.load_byte),
		.re(accept),
		.raddr(rd_wide[AW-1:0]),
		.rdata(buf_byte)
	);

	i2cmts_step #(
		.WRITE_DEPTH(WRITE_DEPTH)
	) u_step (
		.item(item_s1),
		.cfg(cfg_q),
		.st(st_q),
		.buf_byte(buf_byte),
		.res(res_d),
		.st_next(st_next)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, last_status: ST_OK, default: '0};
		end else if (s1_go) begin
			st_q <= st_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			res_q <= res_d;
		end
	end

	`I2CMTS_ASSERT_NOW(a_active_phase, st_q.active, (st_q.phase != PH_IDLE) && (st_q.phase != PH_DONE) && (st_q.phase != PH_ERROR), "active transaction in a resting phase")
	`I2CMTS_ASSERT_NOW(a_sent_bound, 1'b1, 9'(st_q.sent_count) <= 9'(WRITE_DEPTH), "sent count beyond buffer depth")
	`I2CMTS_ASSERT_NOW(a_stall_full, item_stall, valid_s1 && res_valid_q, "input stalled with room to spare")
	`I2CMTS_ASSERT_NEXT(a_stage_moves, s1_go, res_valid_q, "processed item lost before result register")
	`I2CMTS_ASSERT_NOW(a_finish_status, res_valid_q && res_q.finished, res_q.status != ST_BUSY, "finished result carries busy status")

endmodule

/* rtl/i2cmts_ram.sv */
// generic single-port-write ram with registered read
// no dependencies
module i2cmts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/i2cmts_step.sv */
// next-state and result logic for one item of the transaction sequencer
// depends on i2cmts_pkg
module i2cmts_step #(
	parameter int WRITE_DEPTH = i2cmts_pkg::WRITE_DEPTH_DEF
) (
	input  i2cmts_pkg::in_t    item,
	input  i2cmts_pkg::cfg_t   cfg,
	input  i2cmts_pkg::state_t st,
	input  logic [7:0]         buf_byte,
	output i2cmts_pkg::out_t   res,
	output i2cmts_pkg::state_t st_next
);
	import i2cmts_pkg::*;

	logic [4:0] eff_wr;
	logic [4:0] eff_rd;
	logic [4:0] rx_left;
	logic [4:0] rx_inc;
	logic       busy;

	assign eff_wr = (9'(cfg.write_length) > 9'(WRITE_DEPTH)) ? 5'(WRITE_DEPTH)
		: cfg.write_length;
	assign eff_rd = (9'(cfg.read_length) > 9'(READ_DEPTH)) ? 5'(READ_DEPTH)
		: cfg.read_length;
	assign rx_left = eff_rd - st.received_count;
	assign rx_inc = st.received_count + 5'd1;

	always_comb begin
		res = '0;
		st_next = st;
		busy = 1'b0;
		case (action_t'(item.action))
			ACT_LOAD: begin
			end
			ACT_START: begin
				if (st.active || item.bus_busy) begin
					busy = 1'b1;
				end else begin
					st_next.active = 1'b1;
					st_next.remaining_write_length = eff_wr;
					st_next.sent_count = '0;
					st_next.received_count = '0;
					st_next.last_status = ST_OK;
					st_next.phase = PH_START;
					res.event_irq_control = CTL_ENABLE;
					res.issue_start = 1'b1;
				end
			end
			ACT_BUS: begin
				case (st.phase)
					PH_START: begin
						if (item.flag_start_sent) begin
							st_next.phase = PH_ADDR;
							res.data_write_valid = 1'b1;
							res.data_write_value = {cfg.target_address,
								(st.remaining_write_length == '0)};
						end
					end
					PH_ADDR: begin
						if (item.flag_address_acked) begin
							if (st.remaining_write_length != '0) begin
								st_next.phase = PH_TX;
								res.buffer_irq_control = CTL_ENABLE;
								res.data_write_valid = 1'b1;
								res.data_write_value = buf_byte;
								st_next.sent_count = st.sent_count + 5'd1;
							end else if (eff_rd != '0) begin
								st_next.phase = PH_RX;
								res.buffer_irq_control = CTL_ENABLE;
								if (eff_rd == 5'd1) begin
									res.ack_control = CTL_DISABLE;
									res.issue_stop = 1'b1;
								end else begin
									res.ack_control = CTL_ENABLE;
								end
							end else begin
								res.issue_stop = 1'b1;
								res.event_irq_control = CTL_DISABLE;
								st_next.last_status = ST_OK;
								st_next.phase = PH_DONE;
								st_next.active = 1'b0;
								res.finished = 1'b1;
							end
						end
					end
					PH_TX: begin
						if (item.flag_byte_done
							&& st.sent_count >= st.remaining_write_length) begin
							if (cfg.restart_en && eff_rd != '0) begin
								st_next.remaining_write_length = '0;
								st_next.phase = PH_START;
								res.issue_start = 1'b1;
							end else begin
								res.issue_stop = 1'b1;
								res.event_irq_control = CTL_DISABLE;
								st_next.last_status = ST_OK;
								st_next.phase = PH_DONE;
								st_next.active = 1'b0;
								res.finished = 1'b1;
							end
						end else if (item.flag_tx_empty) begin
							if (st.sent_count < st.remaining_write_length) begin
								res.data_write_valid = 1'b1;
								res.data_write_value = buf_byte;
								st_next.sent_count = st.sent_count + 5'd1;
							end else begin
								res.buffer_irq_control = CTL_DISABLE;
							end
						end
					end
					PH_RX: begin
						if (item.flag_rx_ready) begin
							if (eff_rd > st.received_count && rx_left == 5'd2) begin
								res.ack_control = CTL_DISABLE;
								res.issue_stop = 1'b1;
							end
							res.read_valid = 1'b1;
							res.read_index = st.received_count[3:0];
							res.read_value = item.rx_byte;
							st_next.received_count = rx_inc;
							if (rx_inc >= eff_rd) begin
								res.buffer_irq_control = CTL_DISABLE;
								res.event_irq_control = CTL_DISABLE;
								st_next.last_status = ST_OK;
								st_next.phase = PH_DONE;
								st_next.active = 1'b0;
								res.finished = 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
			ACT_ERROR: begin
				if (item.flag_nack) begin
					st_next.last_status = ST_NACK;
				end else if (item.flag_bus_error) begin
					st_next.last_status = ST_BUSERR;
				end
				st_next.phase = PH_ERROR;
				st_next.active = 1'b0;
				res.issue_stop = 1'b1;
				res.buffer_irq_control = CTL_DISABLE;
				res.event_irq_control = CTL_DISABLE;
				res.finished = 1'b1;
			end
			default: begin
			end
		endcase
		res.status = busy ? ST_BUSY : st_next.last_status;
	end

endmodule
